// ===== src/jlvb_pkg.sv =====
`default_nettype none

package jlvb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int ROOT_W        = DATA_W;
    localparam int REM_W         = ROOT_W + 2;
    localparam int SQRT_STAGES   = ROOT_W;
    localparam int LANES         = 2;
    localparam int LANE_POS      = 0;
    localparam int LANE_NEG      = 1;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [DATA_W-1:0] ACCEL_RESET = 32'h0001_0000;
    localparam logic [DATA_W-1:0] RATE_RESET  = 32'h000A_0000;
    localparam logic [DATA_W-1:0] POS_CAP     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_CAP     = 32'h8000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ACCELERATION = 2'd0,
        REG_SAMPLE_RATE  = 2'd1
    } cfg_reg_t;

    // per-item sideband carried alongside the root pipeline
    typedef struct packed {
        logic [DATA_W-1:0] rate_pos;
        logic [DATA_W-1:0] rate_neg;
        logic              sat_pos;
        logic              sat_neg;
    } tag_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [PROD_W-1:0] rad;
    } sq_t;

    // one digit of the restoring square root: two radicand bits in, one root bit out
    function automatic sq_t sqrt_step(sq_t cur);
        sq_t              nxt;
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] trial;
        r     = {cur.rem[REM_W-3:0], cur.rad[PROD_W-1 -: 2]};
        trial = {cur.root, 2'b01};
        nxt.rad = {cur.rad[PROD_W-3:0], 2'b00};
        if (r >= trial)
        begin
            nxt.rem  = r - trial;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = r;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ===== src/jlvb_front.sv =====
`default_nettype none

module jlvb_front #(
    parameter int FRAC_BITS = jlvb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            adv,
    input  wire logic                                            in_valid,
    input  wire logic signed [jlvb_pkg::DATA_W-1:0]              current_position,
    input  wire logic signed [jlvb_pkg::DATA_W-1:0]              upper_limit,
    input  wire logic signed [jlvb_pkg::DATA_W-1:0]              lower_limit,
    input  wire logic        [jlvb_pkg::DATA_W-1:0]              acceleration,
    input  wire logic        [jlvb_pkg::DATA_W-1:0]              sample_rate,
    output logic                                                 prep_valid,
    output logic [jlvb_pkg::LANES-1:0][jlvb_pkg::PROD_W-1:0]     prep_radicand,
    output jlvb_pkg::tag_t                                       prep_tag
);

    localparam int DW = jlvb_pkg::DATA_W;
    localparam int PW = jlvb_pkg::PROD_W;
    localparam int NL = jlvb_pkg::LANES;
    localparam logic [NL-1:0][DW-1:0] CAPS = {jlvb_pkg::NEG_CAP, jlvb_pkg::POS_CAP};

    logic                   s1_valid_reg;
    logic [NL-1:0][DW-1:0]  s1_dist_reg;
    logic [NL-1:0]          s1_ok_reg;
    logic                   s2_valid_reg;
    logic [NL-1:0][PW-1:0]  s2_rate_prod_reg;
    logic [NL-1:0][PW-1:0]  s2_brake_prod_reg;
    logic [NL-1:0]          s2_ok_reg;

    logic [DW:0]            diff_up;
    logic [DW:0]            diff_dn;
    logic [NL-1:0][DW-1:0]  dist_next;
    logic [NL-1:0]          ok_next;
    logic [NL-1:0][PW-1:0]  rate_full;
    logic [NL-1:0][DW-1:0]  rate_cap;

    always_comb
    begin
        diff_up = {upper_limit[DW-1], upper_limit} - {current_position[DW-1], current_position};
        diff_dn = {current_position[DW-1], current_position} - {lower_limit[DW-1], lower_limit};
        dist_next[jlvb_pkg::LANE_POS] = diff_up[DW-1:0];
        dist_next[jlvb_pkg::LANE_NEG] = diff_dn[DW-1:0];
        ok_next[jlvb_pkg::LANE_POS]   = ~diff_up[DW];
        ok_next[jlvb_pkg::LANE_NEG]   = ~diff_dn[DW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dist_reg <= dist_next;
            s1_ok_reg   <= ok_next;
            s2_ok_reg   <= s1_ok_reg;
            for (int l = 0; l < NL; l++)
            begin
                s2_rate_prod_reg[l]  <= PW'(s1_dist_reg[l]) * PW'(sample_rate);
                s2_brake_prod_reg[l] <= PW'(s1_dist_reg[l]) * PW'(acceleration);
            end
        end
    end

    // rate term is capped here; capping before the min gives the same answer
    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            rate_full[l] = s2_rate_prod_reg[l] >> FRAC_BITS;
            if (!s2_ok_reg[l])
                rate_cap[l] = '0;
            else if (rate_full[l] > PW'(CAPS[l]))
                rate_cap[l] = CAPS[l];
            else
                rate_cap[l] = rate_full[l][DW-1:0];
            prep_radicand[l] = {s2_brake_prod_reg[l][PW-2:0], 1'b0};
        end
        prep_valid        = s2_valid_reg;
        prep_tag.rate_pos = rate_cap[jlvb_pkg::LANE_POS];
        prep_tag.rate_neg = rate_cap[jlvb_pkg::LANE_NEG];
        prep_tag.sat_pos  = s2_brake_prod_reg[jlvb_pkg::LANE_POS][PW-1];
        prep_tag.sat_neg  = s2_brake_prod_reg[jlvb_pkg::LANE_NEG][PW-1];
    end

endmodule

`default_nettype wire

// ===== src/jlvb_sqrt.sv =====
`default_nettype none

module jlvb_sqrt (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            adv,
    input  wire logic                                            src_valid,
    input  wire logic [jlvb_pkg::LANES-1:0][jlvb_pkg::PROD_W-1:0] src_radicand,
    input  wire jlvb_pkg::tag_t                                  src_tag,
    output logic                                                 dst_valid,
    output logic [jlvb_pkg::LANES-1:0][jlvb_pkg::ROOT_W-1:0]     dst_root,
    output jlvb_pkg::tag_t                                       dst_tag
);

    localparam int NS = jlvb_pkg::SQRT_STAGES;
    localparam int NL = jlvb_pkg::LANES;

    logic           [NS-1:0]         valid_reg;
    jlvb_pkg::sq_t  [NS-1:0][NL-1:0] sq_reg;
    jlvb_pkg::tag_t [NS-1:0]         tag_reg;
    jlvb_pkg::sq_t  [NS-1:0][NL-1:0] sq_next;
    jlvb_pkg::sq_t  [NL-1:0]         sq_in;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            sq_in[l].rem  = '0;
            sq_in[l].root = '0;
            sq_in[l].rad  = src_radicand[l];
            sq_next[0][l] = jlvb_pkg::sqrt_step(sq_in[l]);
        end
        for (int s = 1; s < NS; s++)
        begin
            for (int l = 0; l < NL; l++)
                sq_next[s][l] = jlvb_pkg::sqrt_step(sq_reg[s-1][l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NS-2:0], src_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg     <= sq_next;
            tag_reg[0] <= src_tag;
            for (int s = 1; s < NS; s++)
                tag_reg[s] <= tag_reg[s-1];
        end
    end

    always_comb
    begin
        dst_valid = valid_reg[NS-1];
        dst_tag   = tag_reg[NS-1];
        for (int l = 0; l < NL; l++)
            dst_root[l] = sq_reg[NS-1][l].root;
    end

endmodule

`default_nettype wire

// ===== src/jlvb_out.sv =====
`default_nettype none

module jlvb_out (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            last_valid,
    input  wire logic [jlvb_pkg::LANES-1:0][jlvb_pkg::ROOT_W-1:0] last_root,
    input  wire jlvb_pkg::tag_t                                  last_tag,
    output logic                                                 adv,
    output logic                                                 out_valid,
    input  wire logic                                            out_ready,
    output logic        [jlvb_pkg::DATA_W-2:0]                   max_positive_velocity,
    output logic signed [jlvb_pkg::DATA_W-1:0]                   max_negative_velocity
);

    localparam int DW = jlvb_pkg::DATA_W;

    logic                 out_valid_reg;
    logic [DW-2:0]        out_pos_reg;
    logic [DW-1:0]        out_neg_reg;
    logic                 skid_valid_reg;
    logic [DW-2:0]        skid_pos_reg;
    logic [DW-1:0]        skid_neg_reg;

    logic [DW-1:0]        mag_pos;
    logic [DW-1:0]        mag_neg;
    logic [DW-2:0]        pos_next;
    logic [DW-1:0]        neg_next;
    logic                 out_free;

    // a saturated brake term equals the cap, and the rate term is already capped
    always_comb
    begin
        if (last_tag.sat_pos || last_tag.rate_pos < last_root[jlvb_pkg::LANE_POS])
            mag_pos = last_tag.rate_pos;
        else
            mag_pos = last_root[jlvb_pkg::LANE_POS];
        if (last_tag.sat_neg || last_tag.rate_neg < last_root[jlvb_pkg::LANE_NEG])
            mag_neg = last_tag.rate_neg;
        else
            mag_neg = last_root[jlvb_pkg::LANE_NEG];
        pos_next = mag_pos[DW-2:0];
        neg_next = DW'(0) - mag_neg;
    end

    // the skid stage lets the pipe advance once more while a result is held
    assign adv      = ~skid_valid_reg;
    assign out_free = ~out_valid_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg | last_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (adv && last_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_pos_reg <= skid_pos_reg;
                out_neg_reg <= skid_neg_reg;
            end
            else
            begin
                out_pos_reg <= pos_next;
                out_neg_reg <= neg_next;
            end
        end
        else if (adv)
        begin
            skid_pos_reg <= pos_next;
            skid_neg_reg <= neg_next;
        end
    end

    assign out_valid             = out_valid_reg;
    assign max_positive_velocity = out_pos_reg;
    assign max_negative_velocity = out_neg_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output is empty");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_pos_reg)
                                        && $stable(out_neg_reg))
        else $error("held result changed");

    a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_neg_reg[DW-1] || out_neg_reg == '0)
        else $error("negative bound is above zero");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !skid_valid_reg && out_valid_reg && !out_ready && last_valid |=> skid_valid_reg)
        else $error("result dropped while output held");

endmodule

`default_nettype wire

// ===== src/joint_limit_velocity_bound.sv =====
// An input transfer passes 2 front stages, then 32 root stages at one root bit
// each, then 1 output register before out_valid.
// Throughput: one item per cycle while in_ready is high, set by the root pipeline.
// A skid stage keeps in_ready high for one more transfer while a result is held.
// Reset (rst_n low, asynchronous) empties the pipeline and sets acceleration to
// 1.0 and sample_rate to 10.0.
`default_nettype none

module joint_limit_velocity_bound #(
    parameter int FRAC_BITS = jlvb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [jlvb_pkg::DATA_W-1:0]     current_position,
    input  wire logic signed [jlvb_pkg::DATA_W-1:0]     upper_limit,
    input  wire logic signed [jlvb_pkg::DATA_W-1:0]     lower_limit,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic        [jlvb_pkg::DATA_W-2:0]          max_positive_velocity,
    output logic signed [jlvb_pkg::DATA_W-1:0]          max_negative_velocity,
    input  wire logic                                   cfg_write_en,
    input  wire logic [jlvb_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [jlvb_pkg::DATA_W-1:0]            cfg_data
);

    localparam int DW = jlvb_pkg::DATA_W;
    localparam int NL = jlvb_pkg::LANES;

    logic [DW-1:0]                         acceleration_reg;
    logic [DW-1:0]                         sample_rate_reg;
    logic                                  adv;
    logic                                  prep_valid;
    logic [NL-1:0][jlvb_pkg::PROD_W-1:0]   prep_radicand;
    jlvb_pkg::tag_t                        prep_tag;
    logic                                  last_valid;
    logic [NL-1:0][jlvb_pkg::ROOT_W-1:0]   last_root;
    jlvb_pkg::tag_t                        last_tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acceleration_reg <= jlvb_pkg::ACCEL_RESET;
            sample_rate_reg  <= jlvb_pkg::RATE_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                jlvb_pkg::REG_ACCELERATION: acceleration_reg <= cfg_data;
                jlvb_pkg::REG_SAMPLE_RATE:  sample_rate_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready = adv;

    jlvb_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (adv),
        .in_valid         (in_valid),
        .current_position (current_position),
        .upper_limit      (upper_limit),
        .lower_limit      (lower_limit),
        .acceleration     (acceleration_reg),
        .sample_rate      (sample_rate_reg),
        .prep_valid       (prep_valid),
        .prep_radicand    (prep_radicand),
        .prep_tag         (prep_tag)
    );

    jlvb_sqrt u_sqrt (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .src_valid    (prep_valid),
        .src_radicand (prep_radicand),
        .src_tag      (prep_tag),
        .dst_valid    (last_valid),
        .dst_root     (last_root),
        .dst_tag      (last_tag)
    );

    jlvb_out u_out (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .last_valid            (last_valid),
        .last_root             (last_root),
        .last_tag              (last_tag),
        .adv                   (adv),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .max_positive_velocity (max_positive_velocity),
        .max_negative_velocity (max_negative_velocity)
    );

endmodule

`default_nettype wire
